### hdl/exclusive_wait_queue_core_assert.svh
// Assertion macros used by the wait queue port checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef EXCLUSIVE_WAIT_QUEUE_CORE_ASSERT_SVH
`define EXCLUSIVE_WAIT_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EWQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EWQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ewq_pkg.sv
// Shared types and constants of the exclusive wait queue.
// Used by the controller, the top level, both checkers and the testbench; no dependencies.
package ewq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned EntryW     = 9;

  localparam logic OpSleep  = 1'b0;
  localparam logic OpSignal = 1'b1;

  typedef enum logic [1:0] {
    StAccepted = 2'd0,
    StRejected = 2'd1,
    StWoken    = 2'd2,
    StEmpty    = 2'd3
  } status_e;

  typedef enum logic {
    CtrlIdle,
    CtrlPop
  } ctrl_state_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] process_id;
    logic       sleeper_exclusive;
    logic       wake_single;
  } in_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] woken_id;
    logic       woken_exclusive;
    logic       last;
  } out_t;

  typedef struct packed {
    logic       exclusive;
    logic [7:0] process_id;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
    logic            re;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

endpackage

### hdl/exclusive_wait_queue_core.sv
// Exclusive wait queue top level: waiter RAM, controller and output register.
// Depends on ewq_pkg, ewq_ram and ewq_ctrl.
// A sleep, or a signal on an empty queue, is answered combinationally; its result is shown the next cycle.
// A signal that wakes N waiters issues a registered RAM read, then pops one waiter per cycle
// while the output register can take it; results leave at one per cycle while the consumer takes them.
// Reset clears the pointers, the count and the output valid flag; the RAM is not cleared.
module exclusive_wait_queue_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ewq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ewq_pkg::out_t out_data_o
);

  logic              res_valid;
  logic              res_ready;
  ewq_pkg::out_t     res_data;
  ewq_pkg::mem_req_t mem_req;
  ewq_pkg::entry_t   rd_data;
  logic              out_valid_q, out_valid_d;
  ewq_pkg::out_t     out_data_q, out_data_d;

  ewq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data)
  );

  ewq_ram #(
    .Width (ewq_pkg::EntryW),
    .Depth (ewq_pkg::QueueDepth)
  ) u_waiter_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rd_data)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_data_d  = res_data;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hdl/ewq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; the read data holds while no read is issued.
module ewq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ewq_ctrl.sv
// Wait queue controller: ring pointers, sleep and wake sequencing, RAM requests.
// Depends on ewq_pkg.
module ewq_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  ewq_pkg::in_t                 in_data_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output ewq_pkg::out_t                res_data_o,
  output ewq_pkg::mem_req_t            mem_req_o,
  input  ewq_pkg::entry_t              rd_data_i
);

  ewq_pkg::ctrl_state_e             state_q, state_d;
  logic [ewq_pkg::IdxW-1:0]         front_q, front_d;
  logic [ewq_pkg::CntW-1:0]         count_q, count_d;
  logic                             single_q, single_d;
  logic [ewq_pkg::CntW:0]           back_sum;
  logic [ewq_pkg::IdxW-1:0]         front_inc, front_dec;
  logic                             stop;

  always_comb begin
    if (front_q == ewq_pkg::IdxW'(ewq_pkg::QueueDepth - 1)) begin
      front_inc = '0;
    end else begin
      front_inc = front_q + ewq_pkg::IdxW'(1);
    end
    if (front_q == '0) begin
      front_dec = ewq_pkg::IdxW'(ewq_pkg::QueueDepth - 1);
    end else begin
      front_dec = front_q - ewq_pkg::IdxW'(1);
    end
    back_sum = (ewq_pkg::CntW + 1)'(front_q) + (ewq_pkg::CntW + 1)'(count_q);
    if (back_sum >= (ewq_pkg::CntW + 1)'(ewq_pkg::QueueDepth)) begin
      back_sum = back_sum - (ewq_pkg::CntW + 1)'(ewq_pkg::QueueDepth);
    end
  end

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    single_d    = single_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_data_o  = '0;
    mem_req_o   = '0;
    stop        = 1'b0;
    case (state_q)
      ewq_pkg::CtrlIdle: begin
        in_ready_o = res_ready_i;
        if (in_valid_i && res_ready_i) begin
          if (in_data_i.operation == ewq_pkg::OpSleep) begin
            res_valid_o     = 1'b1;
            res_data_o.last = 1'b1;
            if (count_q == ewq_pkg::CntW'(ewq_pkg::QueueDepth)) begin
              res_data_o.status = ewq_pkg::StRejected;
            end else begin
              res_data_o.status          = ewq_pkg::StAccepted;
              mem_req_o.we               = 1'b1;
              mem_req_o.wdata.exclusive  = in_data_i.sleeper_exclusive;
              mem_req_o.wdata.process_id = in_data_i.process_id;
              count_d                    = count_q + ewq_pkg::CntW'(1);
              if (in_data_i.sleeper_exclusive) begin
                mem_req_o.waddr = back_sum[ewq_pkg::IdxW-1:0];
              end else begin
                mem_req_o.waddr = front_dec;
                front_d         = front_dec;
              end
            end
          end else if (count_q == '0) begin
            res_valid_o       = 1'b1;
            res_data_o.status = ewq_pkg::StEmpty;
            res_data_o.last   = 1'b1;
          end else begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = front_q;
            single_d        = in_data_i.wake_single;
            state_d         = ewq_pkg::CtrlPop;
          end
        end
      end
      ewq_pkg::CtrlPop: begin
        if (res_ready_i) begin
          stop = (rd_data_i.exclusive && single_q) || (count_q == ewq_pkg::CntW'(1));
          res_valid_o                = 1'b1;
          res_data_o.status          = ewq_pkg::StWoken;
          res_data_o.woken_id        = rd_data_i.process_id;
          res_data_o.woken_exclusive = rd_data_i.exclusive;
          res_data_o.last            = stop;
          front_d                    = front_inc;
          count_d                    = count_q - ewq_pkg::CntW'(1);
          if (stop) begin
            state_d = ewq_pkg::CtrlIdle;
          end else begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = front_inc;
          end
        end
      end
      default: begin
        state_d = ewq_pkg::CtrlIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ewq_pkg::CtrlIdle;
      front_q  <= '0;
      count_q  <= '0;
      single_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      count_q  <= count_d;
      single_q <= single_d;
    end
  end

endmodule

### hdl/ewq_checker.sv
// Port-level checker for the exclusive wait queue, bound to the top level.
// Depends on ewq_pkg and exclusive_wait_queue_core_assert.svh.
`include "exclusive_wait_queue_core_assert.svh"

module ewq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input ewq_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input ewq_pkg::out_t out_data_o
);

  `EWQ_ASSERT_IMP(a_single_result_last, out_valid_o && out_data_o.status != ewq_pkg::StWoken, out_data_o.last, "A sleep or empty-signal result must close its transfer.")
  `EWQ_ASSERT_IMP(a_non_woken_zero, out_valid_o && out_data_o.status != ewq_pkg::StWoken, out_data_o.woken_id == '0 && !out_data_o.woken_exclusive, "Only a woken result may carry a waiter.")
  `EWQ_ASSERT_IMP(a_busy_during_wake, out_valid_o && !out_data_o.last, !in_ready_o, "No new item may be taken while a wake is still in progress.")
  `EWQ_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "A stalled result must hold.")

endmodule

bind exclusive_wait_queue_core ewq_checker u_ewq_checker (.*);

### tb/sv/wait_queue_checker.sv
// Checker for the exclusive wait queue: watches both channels, keeps its own copy of the
// waiter ring to predict every result, and compares each output transfer field by field.
// Depends on ewq_pkg for the payload types, status codes and queue depth.
module wait_queue_checker
  import ewq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   error_count_o,
  output int   pending_o,
  output int   sleeps_o,
  output int   rejects_o,
  output int   wakeups_o,
  output int   empty_signals_o
);

  entry_t          waiter_ring [QueueDepth];
  logic [IdxW-1:0] ring_front;
  logic [CntW-1:0] ring_fill;
  out_t            awaited_results [$];
  int              errors;
  int              sleeps;
  int              rejects;
  int              wakeups;
  int              empties;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic predict_outcome(input in_t req);
    out_t   res;
    entry_t fresh;
    entry_t popped;
    int     slot;
    bit     stop;
    res = '0;
    res.last = 1'b1;
    if (req.operation == OpSleep) begin
      if (ring_fill >= CntW'(QueueDepth)) begin
        res.status = StRejected;
        rejects++;
      end else begin
        fresh.exclusive = req.sleeper_exclusive;
        fresh.process_id = req.process_id;
        if (req.sleeper_exclusive) begin
          slot = (int'(ring_front) + int'(ring_fill)) % QueueDepth;
        end else begin
          slot = (int'(ring_front) + QueueDepth - 1) % QueueDepth;
          ring_front = IdxW'(slot);
        end
        waiter_ring[slot] = fresh;
        ring_fill++;
        res.status = StAccepted;
        sleeps++;
      end
      awaited_results.push_back(res);
    end else if (ring_fill == '0) begin
      res.status = StEmpty;
      empties++;
      awaited_results.push_back(res);
    end else begin
      do begin
        popped = waiter_ring[ring_front];
        ring_front = IdxW'((int'(ring_front) + 1) % QueueDepth);
        ring_fill--;
        stop = (popped.exclusive && req.wake_single) || ring_fill == '0;
        res.status = StWoken;
        res.woken_id = popped.process_id;
        res.woken_exclusive = popped.exclusive;
        res.last = stop;
        awaited_results.push_back(res);
        wakeups++;
      end while (!stop);
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result with status %0d arrived with nothing awaited",
                                got.status));
    end else begin
      want = awaited_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.woken_id !== want.woken_id)
        report_mismatch($sformatf("woken_id %0d, expected %0d", got.woken_id,
                                  want.woken_id));
      if (got.woken_exclusive !== want.woken_exclusive)
        report_mismatch($sformatf("woken_exclusive %0b, expected %0b", got.woken_exclusive,
                                  want.woken_exclusive));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_results.delete();
      ring_front = '0;
      ring_fill = '0;
      errors = 0;
      sleeps = 0;
      rejects = 0;
      wakeups = 0;
      empties = 0;
      error_count_o <= 0;
      pending_o <= 0;
      sleeps_o <= 0;
      rejects_o <= 0;
      wakeups_o <= 0;
      empty_signals_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (in_valid_i && in_ready_i) predict_outcome(in_data_i);
      error_count_o <= errors;
      pending_o <= awaited_results.size();
      sleeps_o <= sleeps;
      rejects_o <= rejects;
      wakeups_o <= wakeups;
      empty_signals_o <= empties;
    end
  end

endmodule

### tb/sv/testbench.sv
// Top of the wait queue testbench: clock, reset, stimulus, receiver and verdict.
// Depends on ewq_pkg, exclusive_wait_queue_core and wait_queue_checker.
module testbench;
  import ewq_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int LongStall     = 300;
  localparam int TailCycles    = 40;
  localparam int PhaseItems    = 160;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int   send_idle_pct   = 24;
  int   recv_idle_pct   = 88;
  logic long_stall_go   = 1'b0;
  bit   long_stall_done = 1'b0;
  int   idle_cycles     = 0;
  int   sleep_pct       = 60;

  int   error_count;
  int   pending_results;
  int   sleeps;
  int   rejects;
  int   wakeups;
  int   empty_signals;

  always #4 clk_i = ~clk_i;

  exclusive_wait_queue_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  wait_queue_checker queue_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_data_i      (out_data),
    .error_count_o   (error_count),
    .pending_o       (pending_results),
    .sleeps_o        (sleeps),
    .rejects_o       (rejects),
    .wakeups_o       (wakeups),
    .empty_signals_o (empty_signals)
  );

  function automatic in_t sleep_item(input logic [7:0] pid, input logic excl);
    in_t r;
    r.operation = OpSleep;
    r.process_id = pid;
    r.sleeper_exclusive = excl;
    r.wake_single = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic in_t signal_item(input logic single);
    in_t r;
    r.operation = OpSignal;
    r.process_id = 8'($urandom_range(0, 255));
    r.sleeper_exclusive = 1'($urandom_range(0, 1));
    r.wake_single = single;
    return r;
  endfunction

  function automatic in_t random_item(input int pct);
    if ($urandom_range(0, 99) < pct)
      return sleep_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    return signal_item(1'($urandom_range(0, 1)));
  endfunction

  task automatic send_item(input in_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (long_stall_go && !long_stall_done) begin
        long_stall_done = 1'b1;
        repeat (LongStall) begin
          out_ready <= 1'b0;
          @(posedge clk_i);
        end
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL exclusive_wait_queue_core");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(signal_item(1'b1));
    send_item(signal_item(1'b0));
    send_item(sleep_item(8'h00, 1'b0));
    send_item(sleep_item(8'hFF, 1'b1));
    send_item(sleep_item(8'hAA, 1'b1));
    send_item(sleep_item(8'h55, 1'b0));
    send_item(signal_item(1'b1));
    send_item(signal_item(1'b0));
    for (int i = 0; i < QueueDepth + 1; i++)
      send_item(sleep_item(8'($urandom_range(0, 255)), 1'(i % 2)));
    send_item(signal_item(1'b0));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          long_stall_go <= 1'b1;
          repeat (24) send_item(sleep_item(8'($urandom_range(0, 255)),
                                           1'($urandom_range(0, 1))));
        end
      endcase
      for (int i = 0; i < PhaseItems; i++) begin
        if (i % 40 == 0) begin
          case ($urandom_range(0, 2))
            0: sleep_pct = 35;
            1: sleep_pct = 60;
            default: sleep_pct = 85;
          endcase
        end
        send_item(random_item(sleep_pct));
      end
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d accepted sleeps, %0d refused on a full queue, %0d wakeups and %0d %s",
             sleeps, rejects, wakeups, empty_signals, "signals on an empty queue.");
    $display("Idling ran sender-heavy, receiver-heavy and off, with one long receiver hold-off.");
    if (error_count == 0 && pending_results == 0) begin
      $display("PASS exclusive_wait_queue_core");
    end else begin
      $display("FAIL exclusive_wait_queue_core");
    end
    $finish;
  end

endmodule
